>>> sv/spt_pkg.sv
// Shared types and constants of the socket port table.
package spt_pkg;

  localparam int OP_W   = 3;
  localparam int KIND_W = 2;
  localparam int SLOT_W = 6;
  localparam int PORT_W = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOCATE = 3'd0;
  localparam logic [OP_W-1:0] OP_BIND     = 3'd1;
  localparam logic [OP_W-1:0] OP_FREE     = 3'd2;
  localparam logic [OP_W-1:0] OP_CHECK    = 3'd3;
  localparam logic [OP_W-1:0] OP_CLOSE    = 3'd4;

  // The only socket kind that allocate serves
  localparam logic [KIND_W-1:0] SERVED_KIND = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

>>> sv/spt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spt_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/socket_port_table.sv
// Socket port table: slot allocator and port lookup over a scanned RAM.
//
// One input beat carries an operation (allocate, bind, free, check, close)
// with its kind, slot and port; exactly one result beat follows, carrying
// granted_slot and port_open. Both channels use valid/ready, and the block
// takes one operation at a time: in_ready is high only while it is idle.
// Each slot's in-use flag and port sit together in one RAM word, and a
// single comparator walks the slots one per cycle through the registered
// read port, writing back where an entry changes.
// Bind and free read and rewrite only the named slot; allocate walks up from
// slot 1 to the first free slot; check walks until a hit or the last slot;
// close walks every slot from slot 1. Rejected or unknown codes go straight
// to the result beat without a walk. The next input beat is taken only after
// the result beat. After reset a clearing pass zeroes every entry, and
// in_ready stays low meanwhile. A result held by a stalled receiver keeps
// its value and the block takes no new beat until it is taken.
module socket_port_table #(
  parameter int SLOT_COUNT = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [spt_pkg::OP_W-1:0]   in_operation,
  input  logic [spt_pkg::KIND_W-1:0] in_socket_kind,
  input  logic [spt_pkg::SLOT_W-1:0] in_slot,
  input  logic [spt_pkg::PORT_W-1:0] in_port,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [spt_pkg::SLOT_W-1:0] out_granted_slot,
  output logic                       out_port_open
);

  localparam int AW = $clog2(SLOT_COUNT);
  localparam int WW = spt_pkg::PORT_W + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(SLOT_COUNT - 1);
  localparam logic [AW-1:0] FIRST_ADDR = AW'(1);

  spt_pkg::state_t state_r, state_nxt;

  logic [spt_pkg::OP_W-1:0]   op_r, op_nxt;
  logic [spt_pkg::PORT_W-1:0] port_r, port_nxt;
  logic [AW-1:0]              addr_r, addr_nxt;
  logic [AW-1:0]              last_r, last_nxt;
  logic [AW-1:0]              eval_addr_r, eval_addr_nxt;
  logic [AW-1:0]              grant_r, grant_nxt;
  logic                       issue_r, issue_nxt;
  logic                       eval_vld_r, eval_vld_nxt;
  logic                       open_r, open_nxt;

  logic                       in_beat;
  logic                       idx_ok;
  logic                       go_scan;
  logic                       finish;
  logic                       stop_hit;
  logic                       hit;
  logic                       ent_used;
  logic [spt_pkg::PORT_W-1:0] ent_port;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [WW-1:0] wr_data;
  logic [WW-1:0] rd_data;

  spt_ram #(
    .WIDTH (WW),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  assign in_ready         = (state_r == spt_pkg::ST_IDLE);
  assign out_valid        = (state_r == spt_pkg::ST_DONE);
  assign out_granted_slot = spt_pkg::SLOT_W'(grant_r);
  assign out_port_open    = open_r;
  assign in_beat          = in_valid && in_ready;

  assign ent_used = rd_data[WW-1];
  assign ent_port = rd_data[spt_pkg::PORT_W-1:0];
  assign hit      = ent_used && (ent_port == port_r);

  // Decode whether the new beat needs a walk over the table
  always_comb begin
    idx_ok = (in_slot != '0) && (32'(in_slot) < SLOT_COUNT);
    case (in_operation)
      spt_pkg::OP_ALLOCATE: go_scan = (in_socket_kind == spt_pkg::SERVED_KIND);
      spt_pkg::OP_BIND,
      spt_pkg::OP_FREE:     go_scan = idx_ok;
      spt_pkg::OP_CHECK,
      spt_pkg::OP_CLOSE:    go_scan = 1'b1;
      default:              go_scan = 1'b0;
    endcase
  end

  // Judge the entry read back and decide on write-back; zero entries while clearing
  always_comb begin
    stop_hit = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = eval_addr_r;
    wr_data  = rd_data;
    if (state_r == spt_pkg::ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = addr_r;
      wr_data = '0;
    end else if (state_r == spt_pkg::ST_SCAN && eval_vld_r) begin
      case (op_r)
        spt_pkg::OP_ALLOCATE: begin
          if (!ent_used) begin
            stop_hit = 1'b1;
            wr_en    = 1'b1;
            wr_data  = {1'b1, spt_pkg::PORT_W'(eval_addr_r)};
          end
        end
        spt_pkg::OP_BIND: begin
          stop_hit = 1'b1;
          wr_en    = 1'b1;
          wr_data  = {ent_used, port_r};
        end
        spt_pkg::OP_FREE: begin
          stop_hit = 1'b1;
          wr_en    = 1'b1;
          wr_data  = {1'b0, ent_port};
        end
        spt_pkg::OP_CHECK: begin
          stop_hit = hit;
        end
        spt_pkg::OP_CLOSE: begin
          if (hit) begin
            wr_en   = 1'b1;
            wr_data = {1'b0, ent_port};
          end
        end
        default: begin
          stop_hit = 1'b1;
        end
      endcase
    end
    finish = (state_r == spt_pkg::ST_SCAN) && eval_vld_r &&
             (stop_hit || (eval_addr_r == last_r));
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spt_pkg::ST_CLEAR: begin
        if (addr_r == LAST_ADDR) state_nxt = spt_pkg::ST_IDLE;
      end
      spt_pkg::ST_IDLE: begin
        if (in_beat) state_nxt = go_scan ? spt_pkg::ST_SCAN : spt_pkg::ST_DONE;
      end
      spt_pkg::ST_SCAN: begin
        if (finish) state_nxt = spt_pkg::ST_DONE;
      end
      spt_pkg::ST_DONE: begin
        if (out_ready) state_nxt = spt_pkg::ST_IDLE;
      end
      default: state_nxt = spt_pkg::ST_IDLE;
    endcase
  end

  // Sequencer datapath: address walk, pipeline of the read, results
  always_comb begin
    op_nxt        = op_r;
    port_nxt      = port_r;
    addr_nxt      = addr_r;
    last_nxt      = last_r;
    eval_addr_nxt = eval_addr_r;
    grant_nxt     = grant_r;
    issue_nxt     = issue_r;
    eval_vld_nxt  = 1'b0;
    open_nxt      = open_r;
    case (state_r)
      spt_pkg::ST_CLEAR: begin
        if (addr_r != LAST_ADDR) addr_nxt = addr_r + AW'(1);
      end
      spt_pkg::ST_IDLE: begin
        if (in_beat) begin
          op_nxt    = in_operation;
          port_nxt  = in_port;
          grant_nxt = '0;
          open_nxt  = 1'b0;
          issue_nxt = go_scan;
          if (in_operation == spt_pkg::OP_BIND || in_operation == spt_pkg::OP_FREE) begin
            addr_nxt = AW'(in_slot);
            last_nxt = AW'(in_slot);
          end else begin
            addr_nxt = FIRST_ADDR;
            last_nxt = LAST_ADDR;
          end
        end
      end
      spt_pkg::ST_SCAN: begin
        // Issue the next read while the previous entry is judged
        if (issue_r && !finish) begin
          eval_vld_nxt  = 1'b1;
          eval_addr_nxt = addr_r;
          if (addr_r == last_r) begin
            issue_nxt = 1'b0;
          end else begin
            addr_nxt = addr_r + AW'(1);
          end
        end
        if (finish) begin
          issue_nxt = 1'b0;
          if (op_r == spt_pkg::OP_ALLOCATE && stop_hit) grant_nxt = eval_addr_r;
          if (op_r == spt_pkg::OP_CHECK && stop_hit) open_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= spt_pkg::ST_CLEAR;
      addr_r     <= '0;
      issue_r    <= 1'b0;
      eval_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      addr_r     <= addr_nxt;
      issue_r    <= issue_nxt;
      eval_vld_r <= eval_vld_nxt;
    end
    op_r        <= op_nxt;
    port_r      <= port_nxt;
    last_r      <= last_nxt;
    eval_addr_r <= eval_addr_nxt;
    grant_r     <= grant_nxt;
    open_r      <= open_nxt;
  end

endmodule

>>> test/tb_socket_port_table.sv
// Self-checking testbench for the socket port table: random beats against a slot-table predictor.
`timescale 1ns / 100ps

module tb_socket_port_table;

  localparam int SLOTS       = 64;
  localparam int SLOT_IW     = $clog2(SLOTS);
  localparam int TARGET_OPS  = 1850;
  localparam int SETTLE      = SLOTS + 16;
  localparam int LONG_HOLD   = 400;

  // Codes beyond close; the block must ignore them
  localparam logic [spt_pkg::OP_W-1:0] OP_UNDEF5 = 3'd5;
  localparam logic [spt_pkg::OP_W-1:0] OP_UNDEF6 = 3'd6;
  localparam logic [spt_pkg::OP_W-1:0] OP_UNDEF7 = 3'd7;

  typedef struct packed {
    logic [spt_pkg::OP_W-1:0]   code;
    logic [spt_pkg::KIND_W-1:0] kind;
    logic [spt_pkg::SLOT_W-1:0] slot;
    logic [spt_pkg::PORT_W-1:0] port;
  } socket_op_t;

  typedef struct packed {
    logic [spt_pkg::SLOT_W-1:0] granted;
    logic                       open;
  } socket_result_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [spt_pkg::OP_W-1:0]     in_operation = '0;
  logic [spt_pkg::KIND_W-1:0]   in_socket_kind = '0;
  logic [spt_pkg::SLOT_W-1:0]   in_slot = '0;
  logic [spt_pkg::PORT_W-1:0]   in_port = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [spt_pkg::SLOT_W-1:0]   out_granted_slot;
  logic                         out_port_open;

  // Handshake flags from the last rising edge, read by the falling-edge drivers
  logic                in_taken = 1'b0;
  logic                out_taken = 1'b0;
  int                  results_seen = 0;
  int                  errors = 0;
  int                  live_ops_queued = 0;

  socket_op_t          pending_ops[$];
  socket_result_t      expected_results[$];

  // Shadow of the table
  logic                       slot_busy[SLOTS];
  logic [spt_pkg::PORT_W-1:0] slot_port_tbl[SLOTS];

  logic [spt_pkg::OP_W-1:0]   live_codes[5] = '{spt_pkg::OP_ALLOCATE, spt_pkg::OP_BIND,
                                                spt_pkg::OP_FREE, spt_pkg::OP_CHECK,
                                                spt_pkg::OP_CLOSE};
  logic [spt_pkg::PORT_W-1:0] hot_ports[4] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h1F90};

  socket_port_table #(.SLOT_COUNT(SLOTS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_socket_kind   (in_socket_kind),
    .in_slot          (in_slot),
    .in_port          (in_port),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted_slot (out_granted_slot),
    .out_port_open    (out_port_open)
  );

  always #1 clk = ~clk;

  // Apply one operation to the shadow table and return the result it yields
  function automatic socket_result_t predict_socket_op(socket_op_t op);
    socket_result_t r;
    bit             placed;
    r = '0;
    placed = 1'b0;
    case (op.code)
      spt_pkg::OP_ALLOCATE: begin
        if (op.kind == spt_pkg::SERVED_KIND) begin
          for (int i = 1; i < SLOTS; i++) begin
            if (!placed && !slot_busy[SLOT_IW'(i)]) begin
              slot_busy[SLOT_IW'(i)] = 1'b1;
              slot_port_tbl[SLOT_IW'(i)] = spt_pkg::PORT_W'(i);
              r.granted = spt_pkg::SLOT_W'(i);
              placed = 1'b1;
            end
          end
        end
      end
      spt_pkg::OP_BIND: begin
        if (op.slot != 0 && op.slot < SLOTS) slot_port_tbl[op.slot] = op.port;
      end
      spt_pkg::OP_FREE: begin
        if (op.slot != 0 && op.slot < SLOTS) slot_busy[op.slot] = 1'b0;
      end
      spt_pkg::OP_CHECK: begin
        for (int i = 1; i < SLOTS; i++) begin
          if (slot_busy[SLOT_IW'(i)] && slot_port_tbl[SLOT_IW'(i)] == op.port) r.open = 1'b1;
        end
      end
      spt_pkg::OP_CLOSE: begin
        for (int i = 1; i < SLOTS; i++) begin
          if (slot_busy[SLOT_IW'(i)] && slot_port_tbl[SLOT_IW'(i)] == op.port)
            slot_busy[SLOT_IW'(i)] = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_op(input logic [spt_pkg::OP_W-1:0] code,
                          input logic [spt_pkg::KIND_W-1:0] kind,
                          input logic [spt_pkg::SLOT_W-1:0] slot,
                          input logic [spt_pkg::PORT_W-1:0] port);
    socket_op_t item;
    item.code = code;
    item.kind = kind;
    item.slot = slot;
    item.port = port;
    pending_ops.push_back(item);
    // Count only beats that can touch the table or yield something
    if (!(code > spt_pkg::OP_CLOSE ||
          (code == spt_pkg::OP_ALLOCATE && kind != spt_pkg::SERVED_KIND) ||
          ((code == spt_pkg::OP_BIND || code == spt_pkg::OP_FREE) && slot == 0)))
      live_ops_queued++;
  endtask

  // Favour ports that allocate hands out and a few hot values, so lookups hit
  function automatic logic [spt_pkg::PORT_W-1:0] pick_port();
    logic [spt_pkg::PORT_W-1:0] p;
    case ($urandom_range(0, 3))
      0, 1:    p = spt_pkg::PORT_W'($urandom_range(0, SLOTS - 1));
      2:       p = hot_ports[2'($urandom_range(0, 3))];
      default: p = spt_pkg::PORT_W'($urandom);
    endcase
    return p;
  endfunction

  // Sample both handshakes, predict accepted beats and check result beats
  always @(posedge clk) begin : check_beats
    socket_op_t     op;
    socket_result_t want;
    in_taken  <= rst_n && in_valid && in_ready;
    out_taken <= rst_n && out_valid && out_ready;
    if (rst_n && in_valid && in_ready) begin
      op.code = in_operation;
      op.kind = in_socket_kind;
      op.slot = in_slot;
      op.port = in_port;
      expected_results.push_back(predict_socket_op(op));
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with nothing expected: granted_slot %0d port_open %0d",
                 $time, out_granted_slot, out_port_open);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_granted_slot !== want.granted) begin
          $display("%0t: granted_slot expected %0d actual %0d",
                   $time, want.granted, out_granted_slot);
          errors++;
        end
        if (out_port_open !== want.open) begin
          $display("%0t: port_open expected %0d actual %0d",
                   $time, want.open, out_port_open);
          errors++;
        end
      end
    end
  end

  // Sender: hold each beat until taken, then idle for a drawn number of cycles
  int tx_gap = 0;
  int tx_quiet = 0;
  always @(negedge clk) begin : feed_ops
    socket_op_t nxt;
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        // hold the beat
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        nxt = pending_ops.pop_front();
        in_valid       <= 1'b1;
        in_operation   <= nxt.code;
        in_socket_kind <= nxt.kind;
        in_slot        <= nxt.slot;
        in_port        <= nxt.port;
        if (tx_quiet > 0) begin
          tx_quiet--;
          tx_gap = 0;
        end else begin
          if ($urandom_range(0, 15) == 0) tx_quiet = $urandom_range(20, 60);
          tx_gap = $urandom_range(0, 10);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: draw a hold, often none, after each result beat, with two long hold-offs
  int rx_hold = 0;
  int rx_quiet = 0;
  always @(negedge clk) begin : drain_results
    if (out_taken) begin
      if (results_seen == 400 || results_seen == 1300) begin
        rx_hold = LONG_HOLD;
      end else if (rx_quiet > 0) begin
        rx_quiet--;
        rx_hold = 0;
      end else begin
        if ($urandom_range(0, 15) == 0) rx_quiet = $urandom_range(20, 60);
        rx_hold = $urandom_range(0, 10);
      end
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin : stimulus
    int n;
    int s;
    logic [spt_pkg::PORT_W-1:0] p;

    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[SLOT_IW'(i)] = 1'b0;
      slot_port_tbl[SLOT_IW'(i)] = '0;
    end

    // Directed: empty table, unserved kinds, bind/free edge slots, close, unknown codes
    queue_op(spt_pkg::OP_CHECK, '0, '0, 16'h0000);
    for (int k = 0; k < 4; k++) queue_op(spt_pkg::OP_ALLOCATE, spt_pkg::KIND_W'(k), '0, '0);
    queue_op(spt_pkg::OP_ALLOCATE, spt_pkg::SERVED_KIND, '0, '0);
    queue_op(spt_pkg::OP_CHECK, '0, '0, 16'd1);
    queue_op(spt_pkg::OP_BIND, '0, 6'd1, 16'hFFFF);
    queue_op(spt_pkg::OP_CHECK, '0, '0, 16'hFFFF);
    queue_op(spt_pkg::OP_CHECK, '0, '0, 16'd1);
    queue_op(spt_pkg::OP_BIND, '1, 6'd0, 16'd5);
    queue_op(spt_pkg::OP_FREE, '1, 6'd0, 16'd5);
    queue_op(spt_pkg::OP_BIND, '0, 6'd63, 16'hABCD);
    queue_op(spt_pkg::OP_CHECK, '0, '0, 16'hABCD);
    queue_op(spt_pkg::OP_FREE, '0, 6'd2, '0);
    queue_op(spt_pkg::OP_ALLOCATE, spt_pkg::SERVED_KIND, '0, '0);
    queue_op(spt_pkg::OP_BIND, '0, 6'd2, 16'hFFFF);
    queue_op(spt_pkg::OP_CLOSE, '0, '0, 16'hFFFF);
    queue_op(spt_pkg::OP_CHECK, '0, '0, 16'hFFFF);
    queue_op(spt_pkg::OP_ALLOCATE, spt_pkg::SERVED_KIND, 6'd63, 16'hFFFF);
    queue_op(OP_UNDEF5, '1, '1, '1);
    queue_op(OP_UNDEF6, spt_pkg::SERVED_KIND, '1, '1);
    queue_op(OP_UNDEF7, '1, 6'd1, 16'd1);
    queue_op(spt_pkg::OP_CLOSE, '0, '0, 16'h0000);

    // Random: mostly meaningful sequences, some noise
    while (live_ops_queued < TARGET_OPS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // fill the table, often past full
          n = $urandom_range(4, 70);
          repeat (n) begin
            if ($urandom_range(0, 7) == 0)
              queue_op(spt_pkg::OP_ALLOCATE, spt_pkg::KIND_W'($urandom),
                       spt_pkg::SLOT_W'($urandom), spt_pkg::PORT_W'($urandom));
            else
              queue_op(spt_pkg::OP_ALLOCATE, spt_pkg::SERVED_KIND,
                       spt_pkg::SLOT_W'($urandom), spt_pkg::PORT_W'($urandom));
          end
        end
        2, 3: begin
          // release scattered slots
          n = $urandom_range(3, 20);
          repeat (n) begin
            s = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, SLOTS - 1);
            queue_op(spt_pkg::OP_FREE, spt_pkg::KIND_W'($urandom), spt_pkg::SLOT_W'(s),
                     spt_pkg::PORT_W'($urandom));
          end
        end
        4, 5: begin
          // rebind a slot, look the port up, maybe close it and look again
          s = $urandom_range(1, SLOTS - 1);
          p = pick_port();
          queue_op(spt_pkg::OP_BIND, spt_pkg::KIND_W'($urandom), spt_pkg::SLOT_W'(s), p);
          queue_op(spt_pkg::OP_CHECK, spt_pkg::KIND_W'($urandom),
                   spt_pkg::SLOT_W'($urandom), p);
          if ($urandom_range(0, 1) == 1) begin
            queue_op(spt_pkg::OP_CLOSE, spt_pkg::KIND_W'($urandom),
                     spt_pkg::SLOT_W'($urandom), p);
            queue_op(spt_pkg::OP_CHECK, spt_pkg::KIND_W'($urandom),
                     spt_pkg::SLOT_W'($urandom), p);
          end
        end
        6: begin
          // share one port across many slots, then close them together
          p = pick_port();
          n = $urandom_range(2, 12);
          repeat (n)
            queue_op(spt_pkg::OP_BIND, '0, spt_pkg::SLOT_W'($urandom_range(1, SLOTS - 1)), p);
          queue_op(spt_pkg::OP_CLOSE, '0, '0, p);
          queue_op(spt_pkg::OP_CHECK, '0, '0, p);
        end
        7: begin
          // noise over every code and every field bit
          n = $urandom_range(3, 10);
          repeat (n)
            queue_op(spt_pkg::OP_W'($urandom), spt_pkg::KIND_W'($urandom),
                     spt_pkg::SLOT_W'($urandom), spt_pkg::PORT_W'($urandom));
        end
        default: begin
          n = $urandom_range(5, 20);
          repeat (n)
            queue_op(live_codes[3'($urandom_range(0, 4))], spt_pkg::KIND_W'($urandom),
                     spt_pkg::SLOT_W'($urandom), pick_port());
        end
      endcase
    end

    // Release reset on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain, then let any stray result show itself
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
